// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion, also checked during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/pisp_pkg.sv =====
// types, constants and result builders for the panel init sequence player
package pisp_pkg;

  localparam int MaxData      = 64;
  localparam int MaxBlobBytes = 4096;
  localparam int TrailerLen   = 5;

  localparam logic [7:0] OpCmd          = 8'h01;
  localparam logic [7:0] OpDelay        = 8'h02;
  localparam logic [7:0] CmdExitSleep   = 8'h11;
  localparam logic [7:0] CmdDisplayOn   = 8'h29;
  localparam logic [7:0] WaitAfterSleep = 8'd120;
  localparam logic [7:0] WaitAfterOn    = 8'd20;

  typedef enum logic [1:0] {
    PH_OPCODE,
    PH_ARG,
    PH_COUNT,
    PH_DATA
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BAD,
    KIND_CMD,
    KIND_DELAY
  } kind_e;

  typedef enum logic [1:0] {
    ACT_WORD,
    ACT_DELAY,
    ACT_ERROR,
    ACT_DONE
  } action_e;

  typedef enum logic [2:0] {
    ERR_SHORT_HDR,
    ERR_COUNT_OVER,
    ERR_SHORT_DATA,
    ERR_DELAY_COUNT,
    ERR_BAD_OPCODE
  } err_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] word_value;
    logic       dc_bit;
    logic       frame_begin;
    logic       frame_end;
    logic [7:0] delay_ms;
    err_e       error_code;
  } res_t;

  typedef struct packed {
    phase_e     phase;
    kind_e      kind;
    logic [7:0] arg;
    logic [6:0] data_left;
    logic       err;
  } parse_t;

  // results one input byte causes: up to two from the record, then the trailer
  typedef struct packed {
    logic [1:0] n_main;
    res_t       main0;
    res_t       main1;
    logic       trailer;
  } plan_t;

  localparam parse_t ParseReset = '{
    phase:     PH_OPCODE,
    kind:      KIND_BAD,
    arg:       8'd0,
    data_left: 7'd0,
    err:       1'b0
  };

  function automatic res_t mk_none();
    res_t r;
    r            = '0;
    r.action     = ACT_WORD;
    r.error_code = ERR_SHORT_HDR;
    return r;
  endfunction

  function automatic res_t mk_word(input logic [7:0] value, input logic dc,
                                   input logic fb, input logic fe);
    res_t r;
    r             = mk_none();
    r.word_value  = value;
    r.dc_bit      = dc;
    r.frame_begin = fb;
    r.frame_end   = fe;
    return r;
  endfunction

  function automatic res_t mk_delay(input logic [7:0] ms);
    res_t r;
    r          = mk_none();
    r.action   = ACT_DELAY;
    r.delay_ms = ms;
    return r;
  endfunction

  function automatic res_t mk_error(input err_e code);
    res_t r;
    r            = mk_none();
    r.action     = ACT_ERROR;
    r.error_code = code;
    return r;
  endfunction

  // wake-up run after a clean blob end
  function automatic res_t trailer_res(input logic [2:0] idx);
    res_t r;
    case (idx)
      3'd0:    r = mk_word(CmdExitSleep, 1'b0, 1'b1, 1'b1);
      3'd1:    r = mk_delay(WaitAfterSleep);
      3'd2:    r = mk_word(CmdDisplayOn, 1'b0, 1'b1, 1'b1);
      3'd3:    r = mk_delay(WaitAfterOn);
      default: begin
        r        = mk_none();
        r.action = ACT_DONE;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/pisp_decode.sv =====
// record parser: next parse state and result plan for one blob byte
module pisp_decode (
  input  pisp_pkg::parse_t state_i,
  input  logic [7:0]       seq_byte_i,
  input  logic [11:0]      bytes_after_i,
  output pisp_pkg::plan_t  plan_o,
  output pisp_pkg::parse_t state_o
);
  import pisp_pkg::*;

  localparam logic [16:0] AfterMax = 17'(MaxBlobBytes - 1);

  logic [11:0] after_s;
  logic        last;
  logic        fault;
  err_e        fault_code;
  logic [6:0]  left_dec;

  assign after_s  = (17'(bytes_after_i) > AfterMax) ? AfterMax[11:0] : bytes_after_i;
  assign last     = (after_s == 12'd0);
  assign left_dec = (state_i.data_left == 7'd0) ? 7'd0 : state_i.data_left - 7'd1;

  always_comb begin
    plan_o.n_main  = 2'd0;
    plan_o.main0   = mk_none();
    plan_o.main1   = mk_none();
    plan_o.trailer = 1'b0;
    state_o        = state_i;
    fault          = 1'b0;
    fault_code     = ERR_SHORT_HDR;

    if (state_i.err) begin
      // swallow bytes until the blob ends
      if (last) begin
        state_o.err = 1'b0;
      end
    end else begin
      case (state_i.phase)
        PH_OPCODE: begin
          if (after_s < 12'd2) begin
            fault = 1'b1;
          end else begin
            state_o.kind  = (seq_byte_i == OpCmd)   ? KIND_CMD :
                            (seq_byte_i == OpDelay) ? KIND_DELAY : KIND_BAD;
            state_o.phase = PH_ARG;
          end
        end
        PH_ARG: begin
          if (last) begin
            fault = 1'b1;
          end else begin
            state_o.arg   = seq_byte_i;
            state_o.phase = PH_COUNT;
          end
        end
        PH_COUNT: begin
          case (state_i.kind)
            KIND_CMD: begin
              if (seq_byte_i > 8'(MaxData)) begin
                fault      = 1'b1;
                fault_code = ERR_COUNT_OVER;
              end else if (after_s < 12'(seq_byte_i)) begin
                fault      = 1'b1;
                fault_code = ERR_SHORT_DATA;
              end else begin
                plan_o.n_main     = 2'd1;
                plan_o.main0      = mk_word(state_i.arg, 1'b0, 1'b1, seq_byte_i == 8'd0);
                state_o.data_left = seq_byte_i[6:0];
                state_o.phase     = (seq_byte_i == 8'd0) ? PH_OPCODE : PH_DATA;
              end
            end
            KIND_DELAY: begin
              if (seq_byte_i != 8'd0) begin
                fault      = 1'b1;
                fault_code = ERR_DELAY_COUNT;
              end else begin
                plan_o.n_main = 2'd1;
                plan_o.main0  = mk_delay(state_i.arg);
                state_o.phase = PH_OPCODE;
              end
            end
            default: begin
              fault      = 1'b1;
              fault_code = ERR_BAD_OPCODE;
            end
          endcase
        end
        default: begin
          // data byte; frame closes on the last one or at a cut-off blob
          plan_o.n_main     = 2'd1;
          plan_o.main0      = mk_word(seq_byte_i, 1'b1, 1'b0,
                                      (state_i.data_left <= 7'd1) || last);
          state_o.data_left = left_dec;
          if (left_dec == 7'd0) begin
            state_o.phase = PH_OPCODE;
          end else if (last) begin
            fault      = 1'b1;
            fault_code = ERR_SHORT_DATA;
          end
        end
      endcase

      if (fault) begin
        if (plan_o.n_main == 2'd0) begin
          plan_o.main0 = mk_error(fault_code);
        end else begin
          plan_o.main1 = mk_error(fault_code);
        end
        plan_o.n_main     = plan_o.n_main + 2'd1;
        state_o.phase     = PH_OPCODE;
        state_o.data_left = 7'd0;
        state_o.err       = !last;
      end

      if (last) begin
        plan_o.trailer    = !fault && (state_o.phase == PH_OPCODE);
        state_o.phase     = PH_OPCODE;
        state_o.data_left = 7'd0;
        state_o.err       = 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/panel_init_sequence_player.sv =====
// top level: panel init sequence player with input register and result register
//
// Blob bytes enter on the in channel (seq_byte_i, bytes_after_i) under valid/ready;
// bytes_after_i is zero on the last byte of a blob. Results leave on the out
// channel, one beat each, last_of_run_o marking the final result of one byte.
// cfg_we_i/cfg_wdata_i set the word format (1: 8-bit words with separate dc,
// 0: 9-bit words); write it only while the block is idle.
// A byte is registered on acceptance; its first result is loaded into the
// output register once that register is free. While the receiver keeps up, a
// byte with zero or one result retires as it loads, so bytes stream at one per
// cycle; a byte with more results holds the input register until its last
// result loads, as the single output register takes one result per cycle (the
// end-of-blob run is up to six). Result-free bytes never wait on the receiver.
// Reset clears the parser to the opcode phase, drops both registers' valid
// flags and sets the 9-bit format. When the receiver stalls, the result holds
// in the output register and the pending byte waits in the input register; one
// more byte is taken only as the pending one retires.
module panel_init_sequence_player (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  seq_byte_i,
  input  logic [11:0] bytes_after_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  action_o,
  output logic [7:0]  word_value_o,
  output logic        dc_bit_o,
  output logic [3:0]  word_bits_o,
  output logic        frame_begin_o,
  output logic        frame_end_o,
  output logic [7:0]  delay_ms_o,
  output logic [2:0]  error_code_o,
  output logic        last_of_run_o
);
  import pisp_pkg::*;

  logic        cfg_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic [11:0] in_after_q;
  parse_t      state_q, state_d;
  plan_t       plan;
  logic [2:0]  idx_q;
  logic [2:0]  total;
  logic [2:0]  main_cnt;
  res_t        cur_res;
  logic        has_res, out_free, load, is_last, consume;
  logic        out_valid_q;
  res_t        out_res_q;
  logic [3:0]  out_bits_q;
  logic        out_last_q;

  pisp_decode u_decode (
    .state_i       (state_q),
    .seq_byte_i    (in_byte_q),
    .bytes_after_i (in_after_q),
    .plan_o        (plan),
    .state_o       (state_d)
  );

  assign main_cnt = {1'b0, plan.n_main};
  assign total    = main_cnt + (plan.trailer ? 3'(TrailerLen) : 3'd0);
  assign has_res  = (total != 3'd0);
  assign out_free = !out_valid_q || out_ready_i;
  assign load     = in_valid_q && has_res && out_free;
  assign is_last  = (idx_q == total - 3'd1);
  assign consume  = in_valid_q && (!has_res || (load && is_last));

  assign in_ready_o = !in_valid_q || consume;

  always_comb begin
    if (idx_q < main_cnt) begin
      cur_res = idx_q[0] ? plan.main1 : plan.main0;
    end else begin
      cur_res = trailer_res(idx_q - main_cnt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= 1'b0;
      in_valid_q  <= 1'b0;
      state_q     <= ParseReset;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (consume) begin
        state_q <= state_d;
        idx_q   <= 3'd0;
      end else if (load) begin
        idx_q <= idx_q + 3'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q  <= seq_byte_i;
      in_after_q <= bytes_after_i;
    end
    if (load) begin
      out_res_q  <= cur_res;
      out_bits_q <= cfg_q ? 4'd8 : 4'd9;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = out_res_q.action;
  assign word_value_o  = out_res_q.word_value;
  assign dc_bit_o      = out_res_q.dc_bit;
  assign word_bits_o   = out_bits_q;
  assign frame_begin_o = out_res_q.frame_begin;
  assign frame_end_o   = out_res_q.frame_end;
  assign delay_ms_o    = out_res_q.delay_ms;
  assign error_code_o  = out_res_q.error_code;
  assign last_of_run_o = out_last_q;

endmodule

// ===== hw/rtl/pisp_checker.sv =====
// port-level checker for the panel init sequence player, bound to the top level
`include "assert_macros.svh"

module pisp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        cfg_wdata_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  seq_byte_i,
  input logic [11:0] bytes_after_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  action_o,
  input logic [7:0]  word_value_o,
  input logic        dc_bit_o,
  input logic [3:0]  word_bits_o,
  input logic        frame_begin_o,
  input logic        frame_end_o,
  input logic [7:0]  delay_ms_o,
  input logic [2:0]  error_code_o,
  input logic        last_of_run_o
);
  import pisp_pkg::*;

  // a stalled result beat holds
  `ASSERT_RST(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(action_o) && $stable(word_value_o) && $stable(last_of_run_o), "result beat changed while stalled")

  `ASSERT_RST(a_done_last, out_valid_o && action_o == ACT_DONE |-> last_of_run_o, "done is not the last result of its byte")

  `ASSERT_RST(a_frame_only_words, out_valid_o && action_o != ACT_WORD |-> !frame_begin_o && !frame_end_o, "frame mark on a non-word result")

  `ASSERT_RST(a_begin_is_cmd, out_valid_o && frame_begin_o |-> action_o == ACT_WORD && !dc_bit_o && (word_bits_o == 4'd8 || word_bits_o == 4'd9), "frame begin on something other than a command word")

  `ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "result valid right after reset")

endmodule

bind panel_init_sequence_player pisp_checker u_pisp_checker (.*);
